/* rtl/mavt_pkg.sv */
// ----------------------------------------------------------------------------
// mavt_pkg
// Shared widths, reset values, register indexes and state type for the
// moving average autoscale tracker.
// ----------------------------------------------------------------------------
package mavt_pkg;

    localparam int WINDOW_LEN_DEF  = 10;
    localparam int PLOT_POINTS_DEF = 100;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int GAIN_W     = 4;
    localparam int CEIL_W     = 12;
    localparam int SPAN_W     = 8;
    localparam int PLOT_W     = 20;
    localparam int BOUND_W    = 21;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 12;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 4'd5;
    localparam logic [CEIL_W-1:0] CEIL_RESET = 12'd500;
    localparam logic [SPAN_W-1:0] SPAN_RESET = 8'd30;

    localparam logic [PLOT_W-1:0] PLOT_MAX = 20'hFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CEIL = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPAN = 8'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WIN,
        S_DIV,
        S_MUL,
        S_PLOT,
        S_OUT
    } t_state;

endpackage

/* rtl/mavt_window.sv */
// ----------------------------------------------------------------------------
// mavt_window
// Sample ring in a one-port-read memory with a running sum and fill count.
// Reads the entry about to be overwritten, then writes and updates the sum.
// ----------------------------------------------------------------------------
module mavt_window #(
    parameter int WINDOW_LEN  = mavt_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = mavt_pkg::SAMPLE_BITS_DEF,
    localparam int FW  = $clog2(WINDOW_LEN + 1),
    localparam int SW  = SAMPLE_BITS + FW,
    localparam int WPW = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    output logic                   o_done,
    output logic [SW-1:0]          o_sum,
    output logic [FW-1:0]          o_fill
);

    logic [SAMPLE_BITS-1:0] r_mem [WINDOW_LEN];
    logic [SAMPLE_BITS-1:0] r_rdata;
    logic [SAMPLE_BITS-1:0] r_sample;
    logic [WPW-1:0]         r_pos;
    logic [FW-1:0]          r_fill;
    logic [SW-1:0]          r_sum;
    logic                   r_upd;
    logic                   r_done;
    logic                   w_full;
    logic [SW-1:0]          w_old;

    assign w_full = (r_fill == FW'(WINDOW_LEN));
    // entries past the fill count were never written and count as zero
    assign w_old  = w_full ? SW'(r_rdata) : '0;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rdata  <= r_mem[r_pos];
            r_sample <= i_sample;
        end
        if (r_upd) begin
            r_mem[r_pos] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_fill <= '0;
            r_sum  <= '0;
            r_upd  <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_upd  <= i_start;
            r_done <= r_upd;
            if (r_upd) begin
                r_sum <= r_sum + SW'(r_sample) - w_old;
                if (r_pos == WPW'(WINDOW_LEN - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
                if (!w_full) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_sum;
    assign o_fill = r_fill;

endmodule

/* rtl/mavt_div.sv */
// ----------------------------------------------------------------------------
// mavt_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mavt_div #(
    parameter int SW = 20,
    parameter int FW = 4,
    localparam int CW = $clog2(SW + 1)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [SW-1:0] i_dividend,
    input  logic [FW-1:0] i_divisor,
    output logic          o_done,
    output logic [SW-1:0] o_quot
);

    logic [SW-1:0] r_q;
    logic [FW-1:0] r_rem;
    logic [FW-1:0] r_d;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;
    logic [FW:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_q[SW-1]};
    assign w_ge    = (w_trial >= {1'b0, r_d});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_d   <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? FW'(w_trial - {1'b0, r_d}) : FW'(w_trial);
            r_q   <= {r_q[SW-2:0], w_ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(SW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

/* rtl/mavt_plot.sv */
// ----------------------------------------------------------------------------
// mavt_plot
// Plotted-value ring in a memory, a min/max scan over every entry at one
// read per cycle, and the widening of the bounds to the minimum span.
// ----------------------------------------------------------------------------
module mavt_plot #(
    parameter int PLOT_POINTS = mavt_pkg::PLOT_POINTS_DEF,
    localparam int PPW = $clog2(PLOT_POINTS),
    localparam int PFW = $clog2(PLOT_POINTS + 1)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic [mavt_pkg::PLOT_W-1:0]         i_value,
    input  logic [mavt_pkg::CEIL_W-1:0]         i_ceiling,
    input  logic [mavt_pkg::SPAN_W-1:0]         i_min_span,
    output logic                                o_done,
    output logic signed [mavt_pkg::BOUND_W-1:0] o_bound_low,
    output logic [mavt_pkg::PLOT_W-1:0]         o_bound_high
);

    localparam int PW = mavt_pkg::PLOT_W;
    localparam int BW = mavt_pkg::BOUND_W;
    localparam int NW = mavt_pkg::SPAN_W + 4;

    logic [PW-1:0]  r_mem [PLOT_POINTS];
    logic [PW-1:0]  r_rdata;
    logic [PPW-1:0] r_pos;
    logic [PFW-1:0] r_fill;
    logic [PPW-1:0] r_addr;
    logic           r_scan;
    logic           r_rd_vld;
    logic           r_rd_live;
    logic           r_rd_last;
    logic           r_fin;
    logic           r_done;
    logic [PW-1:0]  r_lo;
    logic [PW-1:0]  r_hi;
    logic signed [BW-1:0] r_bound_low;
    logic [PW-1:0]  r_bound_high;

    logic [PW-1:0]  w_v;
    logic [PW-1:0]  w_span;
    logic [NW-1:0]  w_need;
    logic [NW-1:0]  w_short;
    logic [NW-2:0]  w_delta;
    logic           w_narrow;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mem[r_pos] <= i_value;
        end
        if (r_scan) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    // entries at or past the fill count were never written: read as zero
    assign w_v = r_rd_live ? r_rdata : '0;

    assign w_span   = r_hi - r_lo;
    assign w_need   = {i_min_span, 4'b0000};
    assign w_narrow = (w_span < PW'(w_need));
    assign w_short  = w_need - NW'(w_span);
    // half the shortfall in whole units, back to Q.4
    assign w_delta  = {w_short[NW-1:5], 4'b0000};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo <= PW'({i_ceiling, 4'b0000});
            r_hi <= '0;
        end else if (r_rd_vld) begin
            if (r_lo > w_v) begin
                r_lo <= w_v;
            end
            if (r_hi < w_v) begin
                r_hi <= w_v;
            end
        end
        if (r_fin) begin
            if (w_narrow) begin
                r_bound_low  <= $signed({1'b0, r_lo}) - $signed(BW'(w_delta));
                r_bound_high <= r_hi + PW'(w_delta);
            end else begin
                r_bound_low  <= $signed({1'b0, r_lo});
                r_bound_high <= r_hi;
            end
        end
        if (r_scan) begin
            r_rd_live <= (PFW'(r_addr) < r_fill);
            r_rd_last <= (r_addr == PPW'(PLOT_POINTS - 1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_fill   <= '0;
            r_addr   <= '0;
            r_scan   <= 1'b0;
            r_rd_vld <= 1'b0;
            r_fin    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_rd_vld <= r_scan;
            r_fin    <= r_rd_vld && r_rd_last;
            r_done   <= r_fin;
            if (i_start) begin
                if (r_pos == PPW'(PLOT_POINTS - 1)) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
                if (r_fill != PFW'(PLOT_POINTS)) begin
                    r_fill <= r_fill + 1'b1;
                end
                r_scan <= 1'b1;
                r_addr <= '0;
            end else if (r_scan) begin
                r_addr <= r_addr + 1'b1;
                if (r_addr == PPW'(PLOT_POINTS - 1)) begin
                    r_scan <= 1'b0;
                end
            end
        end
    end

    assign o_done       = r_done;
    assign o_bound_low  = r_bound_low;
    assign o_bound_high = r_bound_high;

endmodule

/* rtl/moving_average_autoscale_tracker_core.sv */
// ----------------------------------------------------------------------------
// moving_average_autoscale_tracker_core
// Windowed average of magnitude samples, scaled and plotted, with an
// auto-scaled display range taken over the whole plot ring.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carry one Q12.4 sample word. Output
// channel: o_valid / i_stall carry plot value and both bounds. A word moves
// at an edge where valid is high and stall is low.
// Configuration: i_cfg_valid / o_cfg_ready with index and data; ready is
// always high. Write only while no sample is in flight.
// One sample at a time: the next sample can be taken in the cycle after the
// result word of the last one is loaded into the output register. Most of
// the time per sample goes to the plot memory scan (one read per cycle over
// every entry) and the bit-serial divider (one quotient bit per cycle).
// o_stall is low whenever the core is idle, also while a result still waits
// in the output register; a stalled receiver holds the finished word there
// and the next sample waits at the end of its scan until the register frees.
// Reset clears the rings (by fill counts), positions and registers to their
// defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module moving_average_autoscale_tracker_core #(
    parameter int WINDOW_LEN  = mavt_pkg::WINDOW_LEN_DEF,
    parameter int PLOT_POINTS = mavt_pkg::PLOT_POINTS_DEF,
    parameter int SAMPLE_BITS = mavt_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [SAMPLE_BITS-1:0]                i_sample,
    output logic                                  o_valid,
    input  logic                                  i_stall,
    output logic [mavt_pkg::PLOT_W-1:0]           o_plot_value,
    output logic signed [mavt_pkg::BOUND_W-1:0]   o_bound_low,
    output logic [mavt_pkg::PLOT_W-1:0]           o_bound_high,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [mavt_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [mavt_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int FW  = $clog2(WINDOW_LEN + 1);
    localparam int SW  = SAMPLE_BITS + FW;
    localparam int PRW = SW + mavt_pkg::GAIN_W;
    localparam int PW  = mavt_pkg::PLOT_W;
    localparam int EW  = PRW + PW;

    mavt_pkg::t_state r_state, n_state;

    logic [mavt_pkg::GAIN_W-1:0] r_gain;
    logic [mavt_pkg::CEIL_W-1:0] r_ceiling;
    logic [mavt_pkg::SPAN_W-1:0] r_min_span;

    logic [PRW-1:0] r_prod;
    logic [PW-1:0]  r_plot;
    logic           r_out_valid;
    logic [PW-1:0]  r_out_plot;
    logic signed [mavt_pkg::BOUND_W-1:0] r_out_low;
    logic [PW-1:0]  r_out_high;

    logic           w_accept;
    logic           w_win_done;
    logic [SW-1:0]  w_sum;
    logic [FW-1:0]  w_fill;
    logic           w_div_done;
    logic [SW-1:0]  w_quot;
    logic           w_plot_start;
    logic           w_plot_done;
    logic [PW-1:0]  w_plot_sat;
    logic [EW-1:0]  w_prod_ext;
    logic           w_load_out;
    logic signed [mavt_pkg::BOUND_W-1:0] w_bound_low;
    logic [PW-1:0]  w_bound_high;

    assign o_stall     = (r_state != mavt_pkg::S_IDLE);
    assign w_accept    = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= mavt_pkg::GAIN_RESET;
            r_ceiling  <= mavt_pkg::CEIL_RESET;
            r_min_span <= mavt_pkg::SPAN_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mavt_pkg::REG_GAIN:     r_gain     <= i_cfg_data[mavt_pkg::GAIN_W-1:0];
                mavt_pkg::REG_MIN_CEIL: r_ceiling  <= i_cfg_data[mavt_pkg::CEIL_W-1:0];
                mavt_pkg::REG_MIN_SPAN: r_min_span <= i_cfg_data[mavt_pkg::SPAN_W-1:0];
                default: ;
            endcase
        end
    end

    mavt_window #(
        .WINDOW_LEN  (WINDOW_LEN),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_sample (i_sample),
        .o_done   (w_win_done),
        .o_sum    (w_sum),
        .o_fill   (w_fill)
    );

    mavt_div #(
        .SW (SW),
        .FW (FW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_win_done),
        .i_dividend (w_sum),
        .i_divisor  (w_fill),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (w_div_done) begin
            r_prod <= w_quot * r_gain;
        end
        if (w_plot_start) begin
            r_plot <= w_plot_sat;
        end
    end

    // saturate to the plot width
    assign w_prod_ext   = EW'(r_prod);
    assign w_plot_sat   = (w_prod_ext > EW'(mavt_pkg::PLOT_MAX)) ?
                          mavt_pkg::PLOT_MAX : PW'(w_prod_ext);
    assign w_plot_start = (r_state == mavt_pkg::S_MUL);

    mavt_plot #(
        .PLOT_POINTS (PLOT_POINTS)
    ) u_plot (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (w_plot_start),
        .i_value      (w_plot_sat),
        .i_ceiling    (r_ceiling),
        .i_min_span   (r_min_span),
        .o_done       (w_plot_done),
        .o_bound_low  (w_bound_low),
        .o_bound_high (w_bound_high)
    );

    assign w_load_out = (r_state == mavt_pkg::S_OUT) && (!r_out_valid || !i_stall);

    always_comb begin
        n_state = r_state;
        case (r_state)
            mavt_pkg::S_IDLE: if (w_accept)    n_state = mavt_pkg::S_WIN;
            mavt_pkg::S_WIN:  if (w_win_done)  n_state = mavt_pkg::S_DIV;
            mavt_pkg::S_DIV:  if (w_div_done)  n_state = mavt_pkg::S_MUL;
            mavt_pkg::S_MUL:                   n_state = mavt_pkg::S_PLOT;
            mavt_pkg::S_PLOT: if (w_plot_done) n_state = mavt_pkg::S_OUT;
            mavt_pkg::S_OUT:  if (w_load_out)  n_state = mavt_pkg::S_IDLE;
            default:                           n_state = mavt_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mavt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_plot <= r_plot;
            r_out_low  <= w_bound_low;
            r_out_high <= w_bound_high;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_plot_value = r_out_plot;
    assign o_bound_low  = r_out_low;
    assign o_bound_high = r_out_high;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == mavt_pkg::S_WIN))
        else $error("accepted sample did not start the window update");

    a_win_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_win_done |-> (r_state == mavt_pkg::S_WIN))
        else $error("window update finished outside its state");

    a_plot_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_plot_done |-> (r_state == mavt_pkg::S_PLOT))
        else $error("plot scan finished outside its state");

    a_avg_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (w_quot <= SW'({SAMPLE_BITS{1'b1}})))
        else $error("window average exceeds the sample range");

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the moving average autoscale tracker core. Samples
// go in as directed words and then in random bursts of flat, extreme and
// noisy data over several register settings and idling modes. A scoreboard
// tracks the window ring, the plot ring and the bound widening, and compares
// each result word with the oldest predicted one.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SMP_W   = mavt_pkg::SAMPLE_BITS_DEF;
    localparam int CFG_W   = mavt_pkg::CFG_DATA_W;
    localparam int IDX_W   = mavt_pkg::CFG_IDX_W;
    localparam int PLT_W   = mavt_pkg::PLOT_W;
    localparam int BND_W   = mavt_pkg::BOUND_W;

    localparam logic [IDX_W-1:0] REG_SPARE = 8'd3;
    localparam logic [IDX_W-1:0] REG_TOP   = 8'hFF;
    localparam int WIN_LEN    = mavt_pkg::WINDOW_LEN_DEF;
    localparam int PLOT_LEN   = mavt_pkg::PLOT_POINTS_DEF;
    localparam int SETTLE_CYC = 140;
    localparam int PHASES     = 8;
    localparam int PHASE_ITEMS = 235;

    typedef struct packed {
        logic [PLT_W-1:0] plot_value;
        logic [BND_W-1:0] bound_low;
        logic [PLT_W-1:0] bound_high;
    } t_plot_point;

    typedef enum {BURST_RANDOM, BURST_FLAT, BURST_LOW, BURST_HIGH} t_burst_kind;

    class t_plot_range_scoreboard;
        logic [SMP_W-1:0]                  window_ring [WIN_LEN];
        int                                window_pos;
        int                                window_fill;
        logic [PLT_W-1:0]                  plot_ring [PLOT_LEN];
        int                                plot_pos;
        logic [mavt_pkg::GAIN_W-1:0]       gain;
        logic [mavt_pkg::CEIL_W-1:0]       min_ceiling;
        logic [mavt_pkg::SPAN_W-1:0]       min_span;
        t_plot_point                       expected_points [$];
        int                                fail_count;

        function new();
            for (int i = 0; i < WIN_LEN; i++) window_ring[i] = '0;
            for (int i = 0; i < PLOT_LEN; i++) plot_ring[i] = '0;
            window_pos  = 0;
            window_fill = 0;
            plot_pos    = 0;
            gain        = mavt_pkg::GAIN_RESET;
            min_ceiling = mavt_pkg::CEIL_RESET;
            min_span    = mavt_pkg::SPAN_RESET;
            fail_count  = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                mavt_pkg::REG_GAIN:     gain        = data[mavt_pkg::GAIN_W-1:0];
                mavt_pkg::REG_MIN_CEIL: min_ceiling = data[mavt_pkg::CEIL_W-1:0];
                mavt_pkg::REG_MIN_SPAN: min_span    = data[mavt_pkg::SPAN_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_sample(logic [SMP_W-1:0] sample);
            longint      sum;
            longint      avg;
            longint      prod;
            longint      lo;
            longint      hi;
            longint      spread;
            longint      need;
            longint      widen;
            t_plot_point pt;
            sum = 0;
            window_ring[window_pos] = sample;
            window_pos = (window_pos + 1) % WIN_LEN;
            if (window_fill < WIN_LEN) window_fill++;
            for (int i = 0; i < window_fill; i++) sum += window_ring[i];
            avg  = sum / window_fill;
            prod = avg * longint'(gain);
            pt.plot_value = (prod > longint'(mavt_pkg::PLOT_MAX)) ?
                            mavt_pkg::PLOT_MAX : prod[PLT_W-1:0];
            plot_ring[plot_pos] = pt.plot_value;

            lo = longint'(min_ceiling) * 16;
            hi = 0;
            for (int i = 0; i < PLOT_LEN; i++) begin
                if (lo > longint'(plot_ring[i])) lo = plot_ring[i];
                if (hi < longint'(plot_ring[i])) hi = plot_ring[i];
            end
            spread = hi - lo;
            need   = longint'(min_span) * 16;
            // widen both ends by half the shortfall, whole units only
            if (spread < need) begin
                widen = ((need - spread) / 32) * 16;
                hi += widen;
                lo -= widen;
            end
            pt.bound_low  = lo[BND_W-1:0];
            pt.bound_high = hi[PLT_W-1:0];
            plot_pos = (plot_pos + 1) % PLOT_LEN;
            expected_points.push_back(pt);
        endfunction

        function void check_point(t_plot_point got);
            t_plot_point want;
            if (expected_points.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: unexpected result word plot=%0d low=%0d high=%0d",
                             $realtime, got.plot_value, $signed(got.bound_low),
                             got.bound_high);
                return;
            end
            want = expected_points.pop_front();
            if (got.plot_value != want.plot_value || got.bound_low != want.bound_low ||
                got.bound_high != want.bound_high) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("%0t: mismatch plot %0d/%0d low %0d/%0d high %0d/%0d (exp/got)",
                             $realtime, want.plot_value, got.plot_value,
                             $signed(want.bound_low), $signed(got.bound_low),
                             want.bound_high, got.bound_high);
            end
        endfunction

        function int pending();
            return expected_points.size();
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [SMP_W-1:0]       i_sample;
    logic                   o_valid;
    logic                   i_stall;
    logic [PLT_W-1:0]       o_plot_value;
    logic signed [BND_W-1:0] o_bound_low;
    logic [PLT_W-1:0]       o_bound_high;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [IDX_W-1:0]       i_cfg_index;
    logic [CFG_W-1:0]       i_cfg_data;

    t_plot_range_scoreboard sb;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold;

    moving_average_autoscale_tracker_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_plot_value (o_plot_value),
        .o_bound_low  (o_bound_low),
        .o_bound_high (o_bound_high),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #40ms;
        $display("CHECK FAILED");
        $finish;
    end

    // receiver: random stall, or a long hold-off while rx_hold counts down
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold > 0) begin
                rx_hold--;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(99) < rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_sample(i_sample);
            if (o_valid && !i_stall) sb.check_point({o_plot_value, o_bound_low, o_bound_high});
        end
    end

    task automatic send_sample(logic [SMP_W-1:0] sample);
        int gap;
        i_valid  <= 1'b1;
        i_sample <= sample;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct && gap < 40) gap++;
        // now and then a longer gap, so arrivals land anywhere in the scan
        if (tx_idle_pct != 0 && $urandom_range(7) == 0) gap += $urandom_range(1, 160);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic send_burst(t_burst_kind kind, int count);
        logic [SMP_W-1:0] base;
        logic [SMP_W-1:0] word;
        base = SMP_W'($urandom());
        for (int n = 0; n < count; n++) begin
            case (kind)
                BURST_FLAT: begin
                    word = SMP_W'(base + $urandom_range(0, 63));
                end
                BURST_LOW:  word = SMP_W'($urandom_range(0, 15));
                BURST_HIGH: word = SMP_W'($urandom_range(16'hFFF0, 16'hFFFF));
                default:    word = SMP_W'($urandom());
            endcase
            send_sample(word);
        end
    endtask

    logic [SMP_W-1:0] directed_words [16] = '{
        16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0001, 16'h8000, 16'h7FFF,
        16'hAAAA, 16'h5555, 16'h0000, 16'hFFFF, 16'h0010, 16'h0010, 16'h0010, 16'hFFFE
    };
    logic [CFG_W-1:0] phase_gain [PHASES] = '{
        12'hFF0, 12'd15, 12'd1, 12'h7F3, 12'd15, 12'd5, 12'd9, 12'd1
    };
    logic [CFG_W-1:0] phase_ceil [PHASES] = '{
        12'd0, 12'd4095, 12'd0, 12'hFFF, 12'd500, 12'd100, 12'd2000, 12'd4095
    };
    logic [CFG_W-1:0] phase_span [PHASES] = '{
        12'd255, 12'd0, 12'd255, 12'hF1E, 12'd255, 12'hA80, 12'd64, 12'd255
    };

    initial begin
        int          sent;
        int          len;
        int          pick;
        t_burst_kind kind;
        sb           = new();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold      = 0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_sample     = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: window filling, wrap and extremes
        foreach (directed_words[k]) send_sample(directed_words[k]);
        drain();

        for (int ph = 0; ph < PHASES; ph++) begin
            drain();
            repeat (4) @(posedge i_clk);
            if (ph == 6) begin
                write_reg(mavt_pkg::REG_GAIN, CFG_W'($urandom()));
                write_reg(mavt_pkg::REG_MIN_CEIL, CFG_W'($urandom()));
                write_reg(mavt_pkg::REG_MIN_SPAN, CFG_W'($urandom()));
            end else begin
                write_reg(mavt_pkg::REG_GAIN, phase_gain[ph]);
                write_reg(mavt_pkg::REG_MIN_CEIL, phase_ceil[ph]);
                write_reg(mavt_pkg::REG_MIN_SPAN, phase_span[ph]);
            end
            // writes to unused indexes must be dropped
            write_reg((ph % 2 == 0) ? REG_SPARE : REG_TOP, CFG_W'($urandom()));

            case (ph % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 74; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 74; end
                default: begin tx_idle_pct = 25; rx_stall_pct = 25; end
            endcase
            if (ph == 3) rx_hold = 700;

            sent = 0;
            while (sent < PHASE_ITEMS) begin
                pick = $urandom_range(99);
                if (pick < 40) begin
                    kind = BURST_RANDOM;
                    len  = $urandom_range(5, 60);
                end else if (pick < 75) begin
                    kind = BURST_FLAT;
                    len  = $urandom_range(60, 140);
                end else if (pick < 90) begin
                    kind = BURST_LOW;
                    len  = $urandom_range(20, 110);
                end else begin
                    kind = BURST_HIGH;
                    len  = $urandom_range(20, 110);
                end
                if (len > PHASE_ITEMS - sent) len = PHASE_ITEMS - sent;
                send_burst(kind, len);
                sent += len;
                if (ph == 5 && sent > PHASE_ITEMS / 2 && sent - len <= PHASE_ITEMS / 2) drain();
            end
        end

        drain();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.pending() != 0) begin
            sb.fail_count++;
            $display("%0d result words never arrived", sb.pending());
        end
        if (sb.fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
